[design/nlu_pkg.sv]
// Package: widths, constants and helpers shared by the natural log unit.
`default_nettype none
package nlu_pkg;

  localparam int unsigned OperandW  = 32;
  localparam int unsigned LogW      = 30;
  localparam int unsigned FracBits  = 30;
  localparam int unsigned DefSeriesTerms = 10;

  // f*2^30 divide: one quotient bit per cell
  localparam int unsigned DivBits   = 31;

  localparam logic [31:0] Ln2Q30 = 32'd744261118;
  localparam logic [31:0] OneQ30 = 32'h4000_0000;

  // Request carried into the chain: operand already judged.
  typedef struct packed {
    logic        invalid;
    logic [5:0]  expo_off;   // lead position 0..30
    logic [31:0] mant;       // Q1.30 mantissa
  } nlu_req_t;

  // Divider cell state
  typedef struct packed {
    logic        vld;
    logic        invalid;
    logic [5:0]  expo_off;
    logic [32:0] rem;
    logic [32:0] den;
    logic [30:0] quo;
    logic [30:0] low;        // dividend bits still to shift in, MSB first
  } nlu_div_t;

  // Series cell state
  typedef struct packed {
    logic        vld;
    logic        invalid;
    logic [5:0]  expo_off;
    logic [31:0] sq;
    logic [31:0] term;
    logic [35:0] series;
  } nlu_ser_t;

  // Reciprocal of an odd divisor as Q0.40 (ceil), exact for 31-bit dividends + bias
  function automatic logic [40:0] recip_odd(input int unsigned d);
    logic [80:0] one;
    begin
      one = 81'd1 << 40;
      recip_odd = 41'((one + 81'(d) - 81'd1) / 81'(d));
    end
  endfunction

endpackage
`default_nettype wire

[design/nlu_stream_if.sv]
// Valid/ready stream interface with a generic payload.
`default_nettype none
interface nlu_stream_if #(
  parameter int unsigned Width = 32
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/natural_log_unit_core.sv]
// Top level: natural logarithm of Q15.16 into Q5.24 through a chain of cells.
// Throughput: one transaction per cycle; the chain advances whenever the
//   output register is free or being read, so a stall freezes the whole chain.
// The 31-cell divider (one quotient bit per cell) and the two-stage series
//   cells set the latency. Reset clears all valid flags; data is not reset.
`default_nettype none
module natural_log_unit_core
  import nlu_pkg::*;
#(
  parameter int unsigned SERIES_TERMS = DefSeriesTerms
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  nlu_stream_if.sink   in_i,
  nlu_stream_if.source out_o
);
  logic en;
  logic out_vld_q;
  logic [30:0] out_data_q;

  assign en       = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // ---- stage 0: judge operand, find leading one
  logic [31:0] x;
  logic [4:0]  lead;
  logic        lead_found;
  assign x = in_i.data[31:0];
  always_comb begin
    lead = 5'd0;
    lead_found = 1'b0;
    for (int i = 0; i < 31; i++) begin
      if (x[i]) lead = 5'(i);
    end
    lead_found = |x[30:0];
  end

  nlu_req_t r0_q;
  logic     v0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= in_i.valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      r0_q.invalid  <= x[31] || !lead_found;
      r0_q.expo_off <= {1'b0, lead};
      r0_q.mant     <= x << (5'd30 - lead);
    end
  end

  // ---- stage 1: num/den, seed divider (num<<30 + den>>1)
  nlu_div_t div [0:DivBits];
  logic [32:0] den1;
  assign den1 = {1'b0, r0_q.mant} + {1'b0, OneQ30};
  // dividend N = num*2^30 + den/2; N[63:31] < den, so 31 quotient bits cover it
  logic [63:0] dvd;
  assign dvd = ({32'd0, r0_q.mant - OneQ30} << 30) + 64'(den1 >> 1);

  nlu_div_t s1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q.vld <= 1'b0;
    end else if (en) begin
      s1_q.vld      <= v0_q;
      s1_q.invalid  <= r0_q.invalid;
      s1_q.expo_off <= r0_q.expo_off;
      s1_q.den      <= den1;
      s1_q.rem      <= dvd[63:31];
      s1_q.quo      <= 31'd0;
      s1_q.low      <= dvd[30:0];
    end
  end
  assign div[0] = s1_q;

  // divider row: each cell shifts in one dividend bit and makes one quotient bit
  for (genvar g = 0; g < DivBits; g++) begin : g_div
    nlu_div_cell u_cell (
      .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
      .prev_i (div[g]), .next_o (div[g+1])
    );
  end

  // ---- stage 2: f and its square
  nlu_ser_t ser [0:SERIES_TERMS];
  logic [31:0] f;
  logic [63:0] fsq;
  assign f   = {1'b0, div[DivBits].quo};
  assign fsq = 64'(f) * 64'(f) + 64'(OneQ30 >> 1);

  nlu_ser_t s2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q.vld <= 1'b0;
    end else if (en) begin
      s2_q.vld      <= div[DivBits].vld;
      s2_q.invalid  <= div[DivBits].invalid;
      s2_q.expo_off <= div[DivBits].expo_off;
      s2_q.sq       <= fsq[61:30];
      s2_q.term     <= f;
      s2_q.series   <= 36'(f);
    end
  end
  assign ser[0] = s2_q;

  for (genvar k = 1; k <= SERIES_TERMS; k++) begin : g_ser
    nlu_ser_cell #(.K(k)) u_cell (
      .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
      .prev_i (ser[k-1]), .next_o (ser[k])
    );
  end

  // ---- final: exponent term, rounding to Q5.24
  nlu_ser_t fin;
  logic signed [6:0]  expo;
  logic signed [41:0] sum;
  logic signed [41:0] rnd;
  assign fin  = ser[SERIES_TERMS];
  assign expo = 7'(signed'({1'b0, fin.expo_off})) - 7'sd16;
  assign sum  = 42'(expo) * 42'(signed'({1'b0, Ln2Q30}))
              + 42'(signed'({1'b0, fin.series, 1'b0}));
  assign rnd  = (sum + 42'sd32) >>> 6;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= fin.vld;
  end
  always_ff @(posedge clk_i) begin
    if (en) out_data_q <= fin.invalid ? 31'h4000_0000 : {1'b0, rnd[29:0]};
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_data_q;
endmodule
`default_nettype wire

[design/nlu_div_cell.sv]
// One restoring-divide cell: produces one quotient bit per cycle while en_i is high.
`default_nettype none
module nlu_div_cell
  import nlu_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        en_i,
  input  nlu_div_t   prev_i,
  output nlu_div_t   next_o
);
  nlu_div_t d;
  logic [33:0] trial;

  // shift in the next dividend bit, try subtract
  always_comb begin
    d     = prev_i;
    trial = {prev_i.rem, prev_i.low[30]} - {1'b0, prev_i.den};
    d.low = {prev_i.low[29:0], 1'b0};
    if (!trial[33]) begin
      d.rem = trial[32:0];
      d.quo = {prev_i.quo[29:0], 1'b1};
    end else begin
      d.rem = {prev_i.rem[31:0], prev_i.low[30]};
      d.quo = {prev_i.quo[29:0], 1'b0};
    end
  end

  // only the valid flag is reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_o.vld <= 1'b0;
    end else if (en_i) begin
      next_o <= d;
    end
  end
endmodule
`default_nettype wire

[design/nlu_ser_cell.sv]
// One series cell: two stages, term*sq then divide by (2k+1) and accumulate.
`default_nettype none
module nlu_ser_cell
  import nlu_pkg::*;
#(
  parameter int unsigned K = 1
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        en_i,
  input  nlu_ser_t   prev_i,
  output nlu_ser_t   next_o
);
  localparam logic [40:0] Recip = recip_odd(2 * K + 1);
  localparam logic [31:0] Half  = 32'(K);   // (2K+1)>>1

  nlu_ser_t    mid_q;
  logic [63:0] prod;
  logic [31:0] tnew;
  logic [72:0] qprod;
  logic [31:0] addend;

  // stage A: next term, rounded Q.30
  assign prod = 64'(prev_i.term) * 64'(prev_i.sq) + 64'(OneQ30 >> 1);
  assign tnew = prod[61:30];

  // stage B: (term + half) / (2K+1) by reciprocal multiply
  assign qprod  = 73'(mid_q.term + Half) * 73'(Recip);
  assign addend = qprod[71:40];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q.vld  <= 1'b0;
      next_o.vld <= 1'b0;
    end else if (en_i) begin
      mid_q.vld       <= prev_i.vld;
      mid_q.invalid   <= prev_i.invalid;
      mid_q.expo_off  <= prev_i.expo_off;
      mid_q.sq        <= prev_i.sq;
      mid_q.term      <= tnew;
      mid_q.series    <= prev_i.series;
      next_o.vld      <= mid_q.vld;
      next_o.invalid  <= mid_q.invalid;
      next_o.expo_off <= mid_q.expo_off;
      next_o.sq       <= mid_q.sq;
      next_o.term     <= mid_q.term;
      next_o.series   <= mid_q.series + 36'(addend);
    end
  end
endmodule
`default_nettype wire

[design/nlu_checker.sv]
// Port-level checker for the natural log unit, bound to the top level.
`default_nettype none
module nlu_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [30:0] out_data
);
  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  // an offered operand stays offered until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_ready |=> in_valid)
    else $error("operand withdrawn before transaction");
  // invalid results carry zero value
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data[30] |-> out_data[29:0] == 30'd0)
    else $error("invalid result not zero");
  // input ready follows output side
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");
  // no result right after reset
  a_rst: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid)
    else $error("result out of reset");
endmodule

bind natural_log_unit_core nlu_checker u_nlu_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.data)
);
`default_nettype wire
